// ===== hdl/lidar_sector_filter_nearest_range_unit_macros.svh =====
// Assertion helpers for the checker of this block.
`ifndef LIDAR_SECTOR_FILTER_NEAREST_RANGE_UNIT_MACROS_SVH
`define LIDAR_SECTOR_FILTER_NEAREST_RANGE_UNIT_MACROS_SVH

// same-cycle implication
`define LSFNR_ASSERT_IMPL(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("%m: check failed");

// next-cycle implication
`define LSFNR_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

// ===== hdl/lsfnr_pkg.sv =====
package lsfnr_pkg;

  localparam int DEF_COORD_BITS        = 16;
  localparam int DEF_CORDIC_ITERATIONS = 16;

  localparam int ANGLE_W   = 16;
  localparam int YREG_W    = 16;
  localparam int RANGE_W   = 18;
  localparam logic [RANGE_W-1:0] RANGE_MAX   = '1;
  localparam logic [RANGE_W-1:0] RANGE_RESET = 18'd255000;

  localparam int ATAN_ENTRIES = 24;
  localparam int ATAN_IDX_W   = $clog2(ATAN_ENTRIES);
  localparam int ATAN_W       = 21;
  localparam int ZACC_W       = 24;
  localparam int Q8_SHIFT     = 8;
  localparam int ANG_SUM_W    = 17;
  localparam logic signed [ZACC_W-1:0]    HALF_TURN_Q8 = 24'sd4608000;
  localparam logic signed [ZACC_W-1:0]    ROUND_Q8     = 24'sd128;
  localparam logic signed [ANG_SUM_W-1:0] FULL_TURN    = 17'sd36000;

  localparam int SQUARE_STEPS = 4;

  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 5;

  typedef enum logic [2:0] {
    REG_FILTER_ENABLE    = 3'd0,
    REG_BYPASS_ALL       = 3'd1,
    REG_BLIND_ANGLE_MIN  = 3'd2,
    REG_BLIND_ANGLE_MAX  = 3'd3,
    REG_BLIND_Y_MIN      = 3'd4,
    REG_BLIND_Y_MAX      = 3'd5,
    REG_MAX_DETECT_RANGE = 3'd6
  } lsfnr_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CORDIC,
    ST_ANGLE,
    ST_TEST,
    ST_SQUARE,
    ST_ROOT,
    ST_ROUND,
    ST_DONE
  } lsfnr_state_t;

  typedef struct packed {
    logic                      filter_enable;
    logic                      bypass_all;
    logic [ANGLE_W-1:0]        blind_angle_min;
    logic [ANGLE_W-1:0]        blind_angle_max;
    logic signed [YREG_W-1:0]  blind_y_min;
    logic signed [YREG_W-1:0]  blind_y_max;
    logic [RANGE_W-1:0]        max_detect_range;
  } lsfnr_cfg_t;

  localparam lsfnr_cfg_t CFG_RESET = '{
    filter_enable:    1'b0,
    bypass_all:       1'b0,
    blind_angle_min:  '0,
    blind_angle_max:  '0,
    blind_y_min:      '0,
    blind_y_max:      '0,
    max_detect_range: RANGE_RESET
  };

  typedef struct packed {
    logic               done;
    logic               keep;
    logic               last;
    logic [RANGE_W-1:0] nearest_range;
  } lsfnr_res_t;

  // atan(2^-i) in 0.01 deg, Q8
  function automatic logic [ATAN_W-1:0] atan_q8(input logic [ATAN_IDX_W-1:0] idx);
    logic [ATAN_W-1:0] v;
    unique case (idx)
      5'd0:    v = 21'd1152000;
      5'd1:    v = 21'd680065;
      5'd2:    v = 21'd359328;
      5'd3:    v = 21'd182400;
      5'd4:    v = 21'd91554;
      5'd5:    v = 21'd45822;
      5'd6:    v = 21'd22916;
      5'd7:    v = 21'd11459;
      5'd8:    v = 21'd5730;
      5'd9:    v = 21'd2865;
      5'd10:   v = 21'd1432;
      5'd11:   v = 21'd716;
      5'd12:   v = 21'd358;
      5'd13:   v = 21'd179;
      5'd14:   v = 21'd90;
      5'd15:   v = 21'd45;
      5'd16:   v = 21'd22;
      5'd17:   v = 21'd11;
      5'd18:   v = 21'd6;
      5'd19:   v = 21'd3;
      5'd20:   v = 21'd1;
      5'd21:   v = 21'd1;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== hdl/lidar_sector_filter_nearest_range_unit.sv =====
// Request to result: a kept point with filtering on runs the CORDIC loop, bearing, window
// test, squaring, square root and rounding; a dropped one ends after the window test; with
// filtering off or bypassed only squaring, square root and rounding run. One request at a
// time; the next is taken once the result has been handed to the output register.
// The CORDIC loop and the one-bit-per-cycle square root run on the shared adder.
// Reset is synchronous, active low: registers to defaults, running minimum to 255000.
module lidar_sector_filter_nearest_range_unit #(
  parameter int COORD_BITS        = lsfnr_pkg::DEF_COORD_BITS,
  parameter int CORDIC_ITERATIONS = lsfnr_pkg::DEF_CORDIC_ITERATIONS
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [lsfnr_pkg::APB_ADDR_W-1:0]      paddr,
  input  logic [lsfnr_pkg::APB_DATA_W-1:0]      pwdata,
  output logic [lsfnr_pkg::APB_DATA_W-1:0]      prdata,
  output logic                                  pready,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [COORD_BITS-1:0]          in_point_x,
  input  logic signed [COORD_BITS-1:0]          in_point_y,
  input  logic signed [COORD_BITS-1:0]          in_point_z,
  input  logic                                  in_scan_last,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [COORD_BITS-1:0]          out_x,
  output logic signed [COORD_BITS-1:0]          out_y,
  output logic signed [COORD_BITS-1:0]          out_z,
  output logic                                  out_keep,
  output logic [lsfnr_pkg::RANGE_W-1:0]         out_nearest_range,
  output logic                                  out_result_last
);

  lsfnr_pkg::lsfnr_cfg_t cfg_r, cfg_nxt;
  lsfnr_pkg::lsfnr_reg_t reg_idx;
  lsfnr_pkg::lsfnr_res_t res;

  logic                            busy, start, take, wr_en;
  logic signed [COORD_BITS-1:0]    res_x, res_y, res_z;

  logic                            out_valid_r, out_valid_nxt;
  logic signed [COORD_BITS-1:0]    out_x_r, out_y_r, out_z_r;
  logic                            out_keep_r, out_last_r;
  logic [lsfnr_pkg::RANGE_W-1:0]   out_range_r;

  assign reg_idx = lsfnr_pkg::lsfnr_reg_t'(paddr[lsfnr_pkg::APB_ADDR_W-1:2]);
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (reg_idx)
        lsfnr_pkg::REG_FILTER_ENABLE:    cfg_nxt.filter_enable = pwdata[0];
        lsfnr_pkg::REG_BYPASS_ALL:       cfg_nxt.bypass_all = pwdata[0];
        lsfnr_pkg::REG_BLIND_ANGLE_MIN:
          cfg_nxt.blind_angle_min = pwdata[lsfnr_pkg::ANGLE_W-1:0];
        lsfnr_pkg::REG_BLIND_ANGLE_MAX:
          cfg_nxt.blind_angle_max = pwdata[lsfnr_pkg::ANGLE_W-1:0];
        lsfnr_pkg::REG_BLIND_Y_MIN:
          cfg_nxt.blind_y_min = pwdata[lsfnr_pkg::YREG_W-1:0];
        lsfnr_pkg::REG_BLIND_Y_MAX:
          cfg_nxt.blind_y_max = pwdata[lsfnr_pkg::YREG_W-1:0];
        lsfnr_pkg::REG_MAX_DETECT_RANGE:
          cfg_nxt.max_detect_range = pwdata[lsfnr_pkg::RANGE_W-1:0];
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      lsfnr_pkg::REG_FILTER_ENABLE:
        prdata = lsfnr_pkg::APB_DATA_W'(cfg_r.filter_enable);
      lsfnr_pkg::REG_BYPASS_ALL:
        prdata = lsfnr_pkg::APB_DATA_W'(cfg_r.bypass_all);
      lsfnr_pkg::REG_BLIND_ANGLE_MIN:
        prdata = lsfnr_pkg::APB_DATA_W'(cfg_r.blind_angle_min);
      lsfnr_pkg::REG_BLIND_ANGLE_MAX:
        prdata = lsfnr_pkg::APB_DATA_W'(cfg_r.blind_angle_max);
      lsfnr_pkg::REG_BLIND_Y_MIN:
        prdata = lsfnr_pkg::APB_DATA_W'($unsigned(cfg_r.blind_y_min));
      lsfnr_pkg::REG_BLIND_Y_MAX:
        prdata = lsfnr_pkg::APB_DATA_W'($unsigned(cfg_r.blind_y_max));
      lsfnr_pkg::REG_MAX_DETECT_RANGE:
        prdata = lsfnr_pkg::APB_DATA_W'(cfg_r.max_detect_range);
      default: prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= lsfnr_pkg::CFG_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign start    = in_valid && !busy;
  assign in_stall = busy;
  assign take     = !out_valid_r || !out_stall;

  lsfnr_core #(
    .COORD_BITS        (COORD_BITS),
    .CORDIC_ITERATIONS (CORDIC_ITERATIONS)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .start   (start),
    .pt_x    (in_point_x),
    .pt_y    (in_point_y),
    .pt_z    (in_point_z),
    .pt_last (in_scan_last),
    .take    (take),
    .busy    (busy),
    .res     (res),
    .res_x   (res_x),
    .res_y   (res_y),
    .res_z   (res_z)
  );

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res.done) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res.done) begin
      out_x_r     <= res_x;
      out_y_r     <= res_y;
      out_z_r     <= res_z;
      out_keep_r  <= res.keep;
      out_last_r  <= res.last;
      out_range_r <= res.nearest_range;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_x             = out_x_r;
  assign out_y             = out_y_r;
  assign out_z             = out_z_r;
  assign out_keep          = out_keep_r;
  assign out_nearest_range = out_range_r;
  assign out_result_last   = out_last_r;

endmodule

// ===== hdl/lsfnr_core.sv =====
module lsfnr_core #(
  parameter int COORD_BITS        = lsfnr_pkg::DEF_COORD_BITS,
  parameter int CORDIC_ITERATIONS = lsfnr_pkg::DEF_CORDIC_ITERATIONS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  lsfnr_pkg::lsfnr_cfg_t         cfg,
  input  logic                          start,
  input  logic signed [COORD_BITS-1:0]  pt_x,
  input  logic signed [COORD_BITS-1:0]  pt_y,
  input  logic signed [COORD_BITS-1:0]  pt_z,
  input  logic                          pt_last,
  input  logic                          take,
  output logic                          busy,
  output lsfnr_pkg::lsfnr_res_t         res,
  output logic signed [COORD_BITS-1:0]  res_x,
  output logic signed [COORD_BITS-1:0]  res_y,
  output logic signed [COORD_BITS-1:0]  res_z
);

  localparam int SUM_W     = 2 * COORD_BITS;
  localparam int CW        = COORD_BITS + 11;
  localparam int DW        = (CW > SUM_W + 2) ? CW : SUM_W + 2;
  localparam int MAX_STEPS = (CORDIC_ITERATIONS > COORD_BITS) ? CORDIC_ITERATIONS : COORD_BITS;
  localparam int CNT_W     = $clog2(MAX_STEPS);
  localparam int YC_W      = (COORD_BITS > lsfnr_pkg::YREG_W) ? COORD_BITS : lsfnr_pkg::YREG_W;
  localparam logic signed [DW-1:0] ROOT_START = {{(DW-1){1'b0}}, 1'b1} << (SUM_W - 2);

  lsfnr_pkg::lsfnr_state_t state_r, state_nxt;
  logic [CNT_W-1:0]                      cnt_r, cnt_nxt;
  logic signed [DW-1:0]                  a_r, a_nxt;
  logic signed [DW-1:0]                  b_r, b_nxt;
  logic signed [DW-1:0]                  bit_r, bit_nxt;
  logic signed [lsfnr_pkg::ZACC_W-1:0]   z_r, z_nxt;
  logic signed [SUM_W-1:0]               prod_r, prod_nxt;
  logic signed [COORD_BITS-1:0]          x_r, x_nxt, y_r, y_nxt, pz_r, pz_nxt;
  logic                                  last_r, last_nxt;
  logic                                  keep_r, keep_nxt;
  logic [lsfnr_pkg::ANGLE_W-1:0]         bearing_r, bearing_nxt;
  logic [lsfnr_pkg::RANGE_W-1:0]         run_min_r, run_min_nxt;

  // shared adder
  logic signed [DW-1:0] add_op, add_res;
  logic                 add_sub;

  logic signed [DW-1:0]                  a_sh, b_sh, x_init, y_init;
  logic signed [lsfnr_pkg::ZACC_W-1:0]   atan_ext, z_round, z_deg;
  logic signed [lsfnr_pkg::ANG_SUM_W-1:0] ang_s, ang_w;
  logic signed [COORD_BITS-1:0]          m_sel;
  logic signed [SUM_W-1:0]               m_full;
  logic signed [YC_W-1:0]                y_c, ymin_c, ymax_c;
  logic                                  filtering, in_angle, in_band, keep_t, origin, b_neg;
  logic [DW-1:0]                         root_u;
  logic [lsfnr_pkg::RANGE_W-1:0]         rng, new_min;

  assign b_neg    = b_r[DW-1];
  assign a_sh     = a_r >>> cnt_r;
  assign b_sh     = b_r >>> cnt_r;
  assign atan_ext = lsfnr_pkg::ZACC_W'(lsfnr_pkg::atan_q8(lsfnr_pkg::ATAN_IDX_W'(cnt_r)));
  assign add_res  = add_sub ? (a_r - add_op) : (a_r + add_op);
  assign x_init   = DW'(pt_x) <<< lsfnr_pkg::Q8_SHIFT;
  assign y_init   = DW'(pt_y) <<< lsfnr_pkg::Q8_SHIFT;
  assign filtering = cfg.filter_enable && !cfg.bypass_all;
  assign origin   = (x_r == '0) && (y_r == '0);

  always_comb begin
    unique case (cnt_r)
      CNT_W'(0): m_sel = x_r;
      CNT_W'(1): m_sel = y_r;
      default:   m_sel = pz_r;
    endcase
  end
  assign m_full = m_sel * m_sel;

  // bearing rounding and wrap
  assign z_round = z_r + lsfnr_pkg::ROUND_Q8;
  assign z_deg   = z_round >>> lsfnr_pkg::Q8_SHIFT;
  assign ang_s   = lsfnr_pkg::ANG_SUM_W'(z_deg);
  always_comb begin
    priority if (ang_s < 0) begin
      ang_w = ang_s + lsfnr_pkg::FULL_TURN;
    end else if (ang_s >= lsfnr_pkg::FULL_TURN) begin
      ang_w = ang_s - lsfnr_pkg::FULL_TURN;
    end else begin
      ang_w = ang_s;
    end
  end

  // window tests
  assign y_c    = YC_W'(y_r);
  assign ymin_c = YC_W'($signed(cfg.blind_y_min));
  assign ymax_c = YC_W'($signed(cfg.blind_y_max));
  assign in_angle = (cfg.blind_angle_min > cfg.blind_angle_max) ?
                    (bearing_r > cfg.blind_angle_min || bearing_r < cfg.blind_angle_max) :
                    (bearing_r > cfg.blind_angle_min && bearing_r < cfg.blind_angle_max);
  assign in_band  = (ymin_c > ymax_c) ? (y_c > ymin_c || y_c < ymax_c) :
                                        (y_c > ymin_c && y_c < ymax_c);
  assign keep_t   = !(in_angle || in_band);

  // range saturation and running minimum
  assign root_u  = b_r;
  assign rng     = (root_u > DW'(lsfnr_pkg::RANGE_MAX)) ? lsfnr_pkg::RANGE_MAX :
                                                          lsfnr_pkg::RANGE_W'(root_u);
  assign new_min = (keep_r && rng < run_min_r) ? rng : run_min_r;

  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    a_nxt       = a_r;
    b_nxt       = b_r;
    bit_nxt     = bit_r;
    z_nxt       = z_r;
    prod_nxt    = prod_r;
    x_nxt       = x_r;
    y_nxt       = y_r;
    pz_nxt      = pz_r;
    last_nxt    = last_r;
    keep_nxt    = keep_r;
    bearing_nxt = bearing_r;
    run_min_nxt = run_min_r;
    add_op      = '0;
    add_sub     = 1'b0;
    res         = '0;

    unique case (state_r)
      lsfnr_pkg::ST_IDLE: begin
        if (start) begin
          x_nxt    = pt_x;
          y_nxt    = pt_y;
          pz_nxt   = pt_z;
          last_nxt = pt_last;
          cnt_nxt  = '0;
          if (filtering) begin
            a_nxt     = pt_x[COORD_BITS-1] ? -x_init : x_init;
            b_nxt     = pt_x[COORD_BITS-1] ? -y_init : y_init;
            z_nxt     = pt_x[COORD_BITS-1] ? lsfnr_pkg::HALF_TURN_Q8 : '0;
            state_nxt = lsfnr_pkg::ST_CORDIC;
          end else begin
            keep_nxt  = 1'b1;
            a_nxt     = '0;
            prod_nxt  = '0;
            state_nxt = lsfnr_pkg::ST_SQUARE;
          end
        end
      end
      lsfnr_pkg::ST_CORDIC: begin
        add_op  = b_sh;
        add_sub = b_neg;
        a_nxt   = add_res;
        b_nxt   = b_neg ? (b_r + a_sh) : (b_r - a_sh);
        z_nxt   = b_neg ? (z_r - atan_ext) : (z_r + atan_ext);
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(CORDIC_ITERATIONS - 1)) begin
          state_nxt = lsfnr_pkg::ST_ANGLE;
        end
      end
      lsfnr_pkg::ST_ANGLE: begin
        bearing_nxt = origin ? '0 : lsfnr_pkg::ANGLE_W'(ang_w);
        state_nxt   = lsfnr_pkg::ST_TEST;
      end
      lsfnr_pkg::ST_TEST: begin
        keep_nxt = keep_t;
        if (keep_t) begin
          a_nxt     = '0;
          prod_nxt  = '0;
          cnt_nxt   = '0;
          state_nxt = lsfnr_pkg::ST_SQUARE;
        end else begin
          state_nxt = lsfnr_pkg::ST_DONE;
        end
      end
      lsfnr_pkg::ST_SQUARE: begin
        add_op   = DW'(prod_r);
        a_nxt    = add_res;
        prod_nxt = m_full;
        cnt_nxt  = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(lsfnr_pkg::SQUARE_STEPS - 1)) begin
          cnt_nxt   = '0;
          b_nxt     = '0;
          bit_nxt   = ROOT_START;
          state_nxt = lsfnr_pkg::ST_ROOT;
        end
      end
      lsfnr_pkg::ST_ROOT: begin
        add_op  = b_r | bit_r;
        add_sub = 1'b1;
        if (!add_res[DW-1]) begin
          a_nxt = add_res;
          b_nxt = (b_r >>> 1) | bit_r;
        end else begin
          b_nxt = b_r >>> 1;
        end
        bit_nxt = bit_r >>> 2;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(COORD_BITS - 1)) begin
          state_nxt = lsfnr_pkg::ST_ROUND;
        end
      end
      lsfnr_pkg::ST_ROUND: begin
        // round to nearest: bump when remainder exceeds root
        add_op  = b_r;
        add_sub = 1'b1;
        if (!add_res[DW-1] && add_res != '0) begin
          b_nxt = b_r + 1'b1;
        end
        state_nxt = lsfnr_pkg::ST_DONE;
      end
      lsfnr_pkg::ST_DONE: begin
        if (take) begin
          res.done          = 1'b1;
          res.keep          = keep_r;
          res.last          = last_r;
          res.nearest_range = last_r ? new_min : '0;
          run_min_nxt       = last_r ? cfg.max_detect_range : new_min;
          state_nxt         = lsfnr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = lsfnr_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= lsfnr_pkg::ST_IDLE;
      run_min_r <= lsfnr_pkg::RANGE_RESET;
    end else begin
      state_r   <= state_nxt;
      run_min_r <= run_min_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r     <= cnt_nxt;
    a_r       <= a_nxt;
    b_r       <= b_nxt;
    bit_r     <= bit_nxt;
    z_r       <= z_nxt;
    prod_r    <= prod_nxt;
    x_r       <= x_nxt;
    y_r       <= y_nxt;
    pz_r      <= pz_nxt;
    last_r    <= last_nxt;
    keep_r    <= keep_nxt;
    bearing_r <= bearing_nxt;
  end

  assign busy  = (state_r != lsfnr_pkg::ST_IDLE);
  assign res_x = x_r;
  assign res_y = y_r;
  assign res_z = pz_r;

endmodule

// ===== hdl/lsfnr_chk.sv =====
`include "lidar_sector_filter_nearest_range_unit_macros.svh"

module lsfnr_chk #(
  parameter int COORD_BITS = lsfnr_pkg::DEF_COORD_BITS
) (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_stall,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic signed [COORD_BITS-1:0]      out_x,
  input logic [lsfnr_pkg::RANGE_W-1:0]     out_nearest_range,
  input logic                              out_result_last
);

  // one request in flight: busy straight after a request is taken
  `LSFNR_ASSERT_NEXT(a_busy_after_req, clk, rst_n, in_valid && !in_stall, in_stall)

  `LSFNR_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid)

  `LSFNR_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && out_stall, $stable(out_x) && $stable(out_result_last))

  // range is reported on the last point only
  `LSFNR_ASSERT_IMPL(a_range_last_only, clk, rst_n, out_valid && !out_result_last, out_nearest_range == '0)

endmodule

bind lidar_sector_filter_nearest_range_unit lsfnr_chk #(
  .COORD_BITS (COORD_BITS)
) u_lsfnr_chk (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_stall          (in_stall),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_x             (out_x),
  .out_nearest_range (out_nearest_range),
  .out_result_last   (out_result_last)
);
